### design/websocket_frame_deframer_unit_assert.svh
// Assertion macros for the WebSocket deframer.
// Included by the top level; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsd assertion failed");
// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsd assertion failed");
`else
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/wsd_pkg.sv
// Shared types and constants for the WebSocket deframer.
// No dependencies; used by the channel interfaces and the top level.
package wsd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [63:0] length_type;
   typedef logic [1:0]  kind_type;
   typedef logic [3:0]  opcode_type;

   localparam kind_type KIND_DATA     = 2'd0;
   localparam kind_type KIND_EMPTY    = 2'd1;
   localparam kind_type KIND_OVERSIZE = 2'd2;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam length_type MAX_LENGTH_RESET = 64'd16777216;

endpackage

### design/wsd_if.sv
// Valid/ready channel interfaces of the WebSocket deframer.
// Depends on wsd_pkg.
interface wsd_req_if import wsd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_rsp_if import wsd_pkg::*; ();
   logic       valid;
   logic       ready;
   kind_type   result_kind;
   byte_type   payload_byte;
   logic       final_fragment;
   opcode_type frame_opcode;
   logic       frame_end;

   modport source (output valid, output result_kind, output payload_byte,
                   output final_fragment, output frame_opcode, output frame_end,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input final_fragment, input frame_opcode, input frame_end,
                   output ready);
endinterface

interface wsd_csr_if import wsd_pkg::*; ();
   logic       valid;
   logic       ready;
   length_type max_payload_length;

   modport source (output valid, output max_payload_length, input ready);
   modport sink   (input valid, input max_payload_length, output ready);
endinterface

### design/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: byte-wide header parser and payload unmasker.
// Depends on wsd_pkg, the channel interfaces in wsd_if.sv and the assert header.
//
// Usage:
//   req_if carries one stream byte per request. Header bytes (first byte, length
//   byte, extended length, mask key) give no response. Each payload byte gives
//   one response of kind data, unmasked, tagged with FIN, opcode and frame_end
//   on the last byte. A zero-length frame gives one empty-frame response; a
//   length above max_payload_length gives one oversize response and the next
//   byte is parsed as a new frame header.
//   csr_if writes max_payload_length; it is always ready. It is to be written
//   only while the block is idle; the block itself does not enforce this.
// Timing:
//   A response is registered and appears the cycle after its request is
//   accepted. One byte is accepted every cycle; the single-entry response
//   register is the only buffer, so req_if.ready drops while a response is held
//   and rsp_if.ready is low.
// Reset:
//   Synchronous, active high. The parser returns to waiting for a first header
//   byte, the response register empties and the limit returns to 16 MiB.
module websocket_frame_deframer_unit
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_if,
   wsd_rsp_if.source  rsp_if,
   wsd_csr_if.sink    csr_if
);

`include "websocket_frame_deframer_unit_assert.svh"

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [4:0] fin_op_ff, fin_op_in;
   logic       mask_ff, mask_in;
   logic [3:0] len_left_ff, len_left_in;
   length_type len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [2:0] key_left_ff, key_left_in;
   logic [1:0] key_pos_ff, key_pos_in;
   length_type limit_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   byte_type   byte_ff, byte_in;
   logic       fin_ff, fin_in;
   opcode_type op_ff, op_in;
   logic       end_ff, end_in;

   logic       req_fire;
   logic       emit;
   logic       len_done;
   logic       hdr_done;
   length_type len_value;
   byte_type   b;
   byte_type   key_byte;

   assign b        = req_if.stream_byte;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_comb begin
      unique case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!mask_ff) begin
         key_byte = '0;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      fin_op_in   = fin_op_ff;
      mask_in     = mask_ff;
      len_left_in = len_left_ff;
      len_in      = len_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      key_pos_in  = key_pos_ff;
      emit        = 1'b0;
      kind_in     = KIND_DATA;
      byte_in     = '0;
      end_in      = 1'b0;
      fin_in      = fin_op_ff[4];
      op_in       = fin_op_ff[3:0];
      len_done    = 1'b0;
      hdr_done    = 1'b0;
      len_value   = {len_ff[55:0], b};

      unique case (phase_ff)
         PH_HDR0: begin
            fin_op_in = {b[7], b[3:0]};
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            mask_in = b[7];
            if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
               len_left_in = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               len_in      = '0;
               phase_in    = PH_EXTLEN;
            end else begin
               len_value = {57'd0, b[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXTLEN: begin
            len_in      = len_value;
            len_left_in = len_left_ff - 4'd1;
            len_done    = (len_left_ff == 4'd1);
         end
         PH_KEY: begin
            key_in      = {key_ff[23:0], b};
            key_left_in = key_left_ff - 3'd1;
            len_value   = len_ff;
            hdr_done    = (key_left_ff == 3'd1);
         end
         PH_PAYLOAD: begin
            key_pos_in = key_pos_ff + 2'd1;
            len_in     = len_ff - 64'd1;
            emit       = 1'b1;
            kind_in    = KIND_DATA;
            byte_in    = b ^ key_byte;
            end_in     = (len_ff == 64'd1);
            if (len_ff == 64'd1) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase

      if (len_done) begin
         len_in = len_value;
         if (len_value > limit_ff) begin
            phase_in = PH_HDR0;
            emit     = 1'b1;
            kind_in  = KIND_OVERSIZE;
            end_in   = 1'b1;
         end else if (mask_in) begin
            key_in      = '0;
            key_left_in = KEY_BYTES;
            phase_in    = PH_KEY;
         end else begin
            key_in   = '0;
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         if (len_value == 64'd0) begin
            phase_in = PH_HDR0;
            emit     = 1'b1;
            kind_in  = KIND_EMPTY;
            end_in   = 1'b1;
         end else begin
            key_pos_in = 2'd0;
            phase_in   = PH_PAYLOAD;
         end
      end

      if (req_if.ready) begin
         rsp_valid_in = req_fire && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= MAX_LENGTH_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff <= phase_in;
         end
         if (csr_if.valid && csr_if.ready) begin
            limit_ff <= csr_if.max_payload_length;
         end
      end
      if (req_fire) begin
         fin_op_ff   <= fin_op_in;
         mask_ff     <= mask_in;
         len_left_ff <= len_left_in;
         len_ff      <= len_in;
         key_ff      <= key_in;
         key_left_ff <= key_left_in;
         key_pos_ff  <= key_pos_in;
      end
      if (req_fire && emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         fin_ff  <= fin_in;
         op_ff   <= op_in;
         end_ff  <= end_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_kind    = kind_ff;
   assign rsp_if.payload_byte   = byte_ff;
   assign rsp_if.final_fragment = fin_ff;
   assign rsp_if.frame_opcode   = op_ff;
   assign rsp_if.frame_end      = end_ff;

   // non-data responses always close a frame and carry no byte
   `WSD_ASSERT_NOW(a_ctrl_rsp_shape, clock, reset,
      rsp_valid_ff && kind_ff != KIND_DATA, end_ff && byte_ff == 8'd0)
   // every accepted payload byte produces a data response
   `WSD_ASSERT_NEXT(a_payload_emits, clock, reset,
      req_fire && phase_ff == PH_PAYLOAD,
      rsp_valid_ff && kind_ff == KIND_DATA)
   // the payload phase never runs with nothing left to count
   `WSD_ASSERT_NOW(a_payload_nonzero, clock, reset,
      phase_ff == PH_PAYLOAD, len_ff != 64'd0)

endmodule
